### design/unique_value_set_table_macros.svh
// assertion macros for the set table
`ifndef UNIQUE_VALUE_SET_TABLE_MACROS_SVH
`define UNIQUE_VALUE_SET_TABLE_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define UVST_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("uvst check failed");
// next-cycle implication
`define UVST_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("uvst check failed");
`else
`define UVST_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define UVST_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

### design/uvst_pkg.sv
`default_nettype none
package uvst_pkg;

    localparam int CAPACITY  = 128;
    localparam int ADDR_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int VAL_W     = 32;
    localparam int IDX_W     = 7;
    localparam int OUT_CNT_W = 8;

    typedef enum logic [1:0] {
        FUNC_INSERT = 2'd0,
        FUNC_REMOVE = 2'd1,
        FUNC_QUERY  = 2'd2,
        FUNC_READ   = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_DUP     = 3'd1,
        ST_FULL    = 3'd2,
        ST_MISSING = 3'd3,
        ST_RANGE   = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        RD_PTR   = 2'd0,
        RD_NEXT  = 2'd1,
        RD_INDEX = 2'd2
    } t_rd_sel;

    typedef enum logic [2:0] {
        S_IDLE  = 3'd0,
        S_START = 3'd1,
        S_CMP   = 3'd2,
        S_SH    = 3'd3,
        S_SH_WR = 3'd4,
        S_POST  = 3'd5,
        S_DONE  = 3'd6
    } t_state;

    typedef struct packed {
        logic    load;
        logic    mem_rd;
        t_rd_sel rd_sel;
        logic    ptr_inc;
        logic    set_found;
        logic    shift_wr;
        logic    post;
        logic    emit;
    } t_cmd;

    typedef struct packed {
        t_func func;
        logic  match;
        logic  last;
        logic  count_zero;
        logic  out_free;
    } t_stat;

endpackage
`default_nettype wire

### design/uvst_ctrl.sv
`default_nettype none
module uvst_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire uvst_pkg::t_stat i_stat,
    output uvst_pkg::t_cmd     o_cmd
);
    import uvst_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_START;
                end
            end
            S_START: begin
                if (i_stat.func == FUNC_READ || i_stat.count_zero) begin
                    n_state = S_POST;
                end else begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                if (i_stat.match) begin
                    n_state = (i_stat.func == FUNC_REMOVE) ? S_SH : S_POST;
                end else if (i_stat.last) begin
                    n_state = S_POST;
                end
            end
            S_SH: begin
                n_state = i_stat.last ? S_POST : S_SH_WR;
            end
            S_SH_WR: begin
                n_state = S_SH;
            end
            S_POST: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_ready = 1'b0;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_ready     = 1'b1;
                o_cmd.load  = i_valid;
            end
            S_START: begin
                o_cmd.mem_rd = 1'b1;
                o_cmd.rd_sel = (i_stat.func == FUNC_READ) ? RD_INDEX : RD_PTR;
            end
            S_CMP: begin
                if (i_stat.match) begin
                    o_cmd.set_found = 1'b1;
                end else if (!i_stat.last) begin
                    o_cmd.mem_rd  = 1'b1;
                    o_cmd.rd_sel  = RD_NEXT;
                    o_cmd.ptr_inc = 1'b1;
                end
            end
            S_SH: begin
                if (!i_stat.last) begin
                    o_cmd.mem_rd = 1'b1;
                    o_cmd.rd_sel = RD_NEXT;
                end
            end
            S_SH_WR: begin
                o_cmd.shift_wr = 1'b1;
                o_cmd.ptr_inc  = 1'b1;
            end
            S_POST: begin
                o_cmd.post = 1'b1;
            end
            S_DONE: begin
                o_cmd.emit = i_stat.out_free;
            end
            default: begin
                o_ready = 1'b0;
            end
        endcase
    end

endmodule
`default_nettype wire

### design/uvst_dp.sv
`default_nettype none
module uvst_dp (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire uvst_pkg::t_func               i_func,
    input  wire logic signed [uvst_pkg::VAL_W-1:0] i_value,
    input  wire logic [uvst_pkg::IDX_W-1:0]    i_index,
    input  wire uvst_pkg::t_cmd                i_cmd,
    output uvst_pkg::t_stat                    o_stat,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic                               o_found,
    output logic signed [uvst_pkg::VAL_W-1:0]  o_read_value,
    output logic [uvst_pkg::OUT_CNT_W-1:0]     o_count,
    output logic                               o_empty_res,
    output uvst_pkg::t_status                  o_status
);
    import uvst_pkg::*;

    logic signed [VAL_W-1:0] r_mem [CAPACITY];
    logic signed [VAL_W-1:0] r_rd_data;

    t_func                   r_func;
    logic signed [VAL_W-1:0] r_value;
    logic [IDX_W-1:0]        r_index;
    logic [CNT_W-1:0]        r_ptr;
    logic [CNT_W-1:0]        r_count;
    logic                    r_found;
    t_status                 r_status;

    logic                    r_o_valid;
    logic                    r_o_found;
    logic signed [VAL_W-1:0] r_o_read_value;
    logic [OUT_CNT_W-1:0]    r_o_count;
    logic                    r_o_empty;
    t_status                 r_o_status;

    logic [CNT_W:0]          w_ptr_next;
    logic [ADDR_W-1:0]       w_rd_addr;
    logic [ADDR_W-1:0]       w_wr_addr;
    logic signed [VAL_W-1:0] w_wr_data;
    logic                    w_wr_en;
    logic                    w_full;
    logic                    w_idx_ok;
    logic                    w_append;
    t_status                 n_status;
    logic [CNT_W-1:0]        n_count;

    assign w_ptr_next = {1'b0, r_ptr} + 1'b1;
    assign w_full     = (r_count >= CNT_W'(CAPACITY));
    assign w_idx_ok   = (32'(r_index) < 32'(r_count));
    assign w_append   = i_cmd.post && (r_func == FUNC_INSERT) && !r_found && !w_full;

    always_comb begin
        unique case (i_cmd.rd_sel)
            RD_PTR:   w_rd_addr = r_ptr[ADDR_W-1:0];
            RD_NEXT:  w_rd_addr = w_ptr_next[ADDR_W-1:0];
            RD_INDEX: w_rd_addr = ADDR_W'(r_index);
            default:  w_rd_addr = r_ptr[ADDR_W-1:0];
        endcase
    end

    // shift moves the word read from ptr+1 down to ptr
    assign w_wr_en   = i_cmd.shift_wr || w_append;
    assign w_wr_addr = i_cmd.shift_wr ? r_ptr[ADDR_W-1:0] : r_count[ADDR_W-1:0];
    assign w_wr_data = i_cmd.shift_wr ? r_rd_data : r_value;

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_rd) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    always_comb begin
        n_status = ST_OK;
        n_count  = r_count;
        unique case (r_func)
            FUNC_INSERT: begin
                if (r_found) begin
                    n_status = ST_DUP;
                end else if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    n_count = r_count + 1'b1;
                end
            end
            FUNC_REMOVE: begin
                if (r_found) begin
                    n_count = r_count - 1'b1;
                end else begin
                    n_status = ST_MISSING;
                end
            end
            FUNC_QUERY: begin
                if (!r_found) begin
                    n_status = ST_MISSING;
                end
            end
            FUNC_READ: begin
                if (!w_idx_ok) begin
                    n_status = ST_RANGE;
                end
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func  <= i_func;
            r_value <= i_value;
            r_index <= i_index;
        end
        if (i_cmd.post) begin
            r_status <= n_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr   <= '0;
            r_count <= '0;
            r_found <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_ptr   <= '0;
                r_found <= 1'b0;
            end else if (i_cmd.ptr_inc) begin
                r_ptr <= w_ptr_next[CNT_W-1:0];
            end
            if (i_cmd.set_found) begin
                r_found <= 1'b1;
            end
            if (i_cmd.post) begin
                r_count <= n_count;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_o_found      <= r_found;
            r_o_read_value <= (r_func == FUNC_READ && r_status == ST_OK) ? r_rd_data : '0;
            r_o_count      <= OUT_CNT_W'(r_count);
            r_o_empty      <= (r_count == '0);
            r_o_status     <= r_status;
        end
    end

    assign o_stat.func       = r_func;
    assign o_stat.match      = (r_rd_data == r_value);
    assign o_stat.last       = (w_ptr_next >= {1'b0, r_count});
    assign o_stat.count_zero = (r_count == '0);
    assign o_stat.out_free   = !r_o_valid || i_ready;

    assign o_valid      = r_o_valid;
    assign o_found      = r_o_found;
    assign o_read_value = r_o_read_value;
    assign o_count      = r_o_count;
    assign o_empty_res  = r_o_empty;
    assign o_status     = r_o_status;

endmodule
`default_nettype wire

### design/unique_value_set_table.sv
// Set of up to 128 distinct signed 32-bit values kept in insertion order in a
// single-port-write, registered-read memory. Each word names insert, remove,
// membership query or read-at-index and yields one result word with found,
// read value, count, empty flag and status. One item is handled at a time:
// the entry scan reads one memory location per cycle. A remove that hits moves
// each entry behind the match down by one place, reading it and writing it
// back, to close the gap. The result sits in an output register, so the next
// word is taken while a result still waits. The memory needs no clearing after
// reset.
`default_nettype none
`include "unique_value_set_table_macros.svh"
module unique_value_set_table (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    output logic                                   o_ready,
    input  wire uvst_pkg::t_func                   i_func,
    input  wire logic signed [uvst_pkg::VAL_W-1:0] i_value,
    input  wire logic [uvst_pkg::IDX_W-1:0]        i_index,
    output logic                                   o_valid,
    input  wire logic                              i_ready,
    output logic                                   o_found,
    output logic signed [uvst_pkg::VAL_W-1:0]      o_read_value,
    output logic [uvst_pkg::OUT_CNT_W-1:0]         o_count,
    output logic                                   o_empty_res,
    output uvst_pkg::t_status                      o_status
);
    import uvst_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    uvst_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    uvst_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_func       (i_func),
        .i_value      (i_value),
        .i_index      (i_index),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_found      (o_found),
        .o_read_value (o_read_value),
        .o_count      (o_count),
        .o_empty_res  (o_empty_res),
        .o_status     (o_status)
    );

    `UVST_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, i_valid && o_ready, !o_ready)
    `UVST_ASSERT_IMP(a_dup_found, i_clk, i_rst_n, o_valid && o_status == ST_DUP, o_found)
    `UVST_ASSERT_IMP(a_range_zero, i_clk, i_rst_n, o_valid && o_status == ST_RANGE, o_read_value == '0)
    `UVST_ASSERT_IMP(a_empty_count, i_clk, i_rst_n, o_valid && o_empty_res, o_count == '0)

endmodule
`default_nettype wire

### tb/unique_value_set_table_test.sv
`default_nettype none
module unique_value_set_table_test;
    import uvst_pkg::*;

    localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;
    localparam int RANDOM_ITEMS = 1150;

    typedef struct {
        logic                      found;
        logic signed [VAL_W-1:0]   read_value;
        logic [OUT_CNT_W-1:0]      count;
        logic                      empty_res;
        t_status                   status;
    } t_set_result;

    typedef struct {
        t_func                     func;
        logic signed [VAL_W-1:0]   value;
        logic [IDX_W-1:0]          index;
        bit                        typed;
        t_set_result               res;
    } t_stim_row;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_valid = 1'b0;
    logic                          o_ready;
    t_func                         i_func = FUNC_INSERT;
    logic signed [VAL_W-1:0]       i_value = '0;
    logic [IDX_W-1:0]              i_index = '0;
    logic                          o_valid;
    logic                          i_ready = 1'b0;
    logic                          o_found;
    logic signed [VAL_W-1:0]       o_read_value;
    logic [OUT_CNT_W-1:0]          o_count;
    logic                          o_empty_res;
    t_status                       o_status;

    logic signed [VAL_W-1:0]       held_values[$];
    t_set_result                   pending_results[$];
    t_stim_row                     directed_rows[$];
    int                            error_count = 0;
    int                            random_sent = 0;
    int                            hold_cycles = 0;
    bit                            quiet_mode = 1'b0;

    unique_value_set_table u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_func       (i_func),
        .i_value      (i_value),
        .i_index      (i_index),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_found      (o_found),
        .o_read_value (o_read_value),
        .o_count      (o_count),
        .o_empty_res  (o_empty_res),
        .o_status     (o_status)
    );

    always #5 i_clk = ~i_clk;

    // set model: insertion order kept, gap closed on remove
    function automatic t_set_result apply_set_op(t_func f, logic signed [VAL_W-1:0] v,
                                                 logic [IDX_W-1:0] idx);
        t_set_result r;
        int pos;
        r.found      = 1'b0;
        r.read_value = '0;
        r.status     = ST_OK;
        pos = -1;
        foreach (held_values[i]) begin
            if (pos < 0 && held_values[i] == v) pos = i;
        end
        case (f)
            FUNC_INSERT: begin
                if (pos >= 0) begin
                    r.found  = 1'b1;
                    r.status = ST_DUP;
                end else if (held_values.size() >= CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    held_values.push_back(v);
                end
            end
            FUNC_REMOVE: begin
                if (pos >= 0) begin
                    r.found = 1'b1;
                    held_values.delete(pos);
                end else begin
                    r.status = ST_MISSING;
                end
            end
            FUNC_QUERY: begin
                if (pos >= 0) r.found = 1'b1;
                else r.status = ST_MISSING;
            end
            default: begin
                if (idx < held_values.size()) r.read_value = held_values[idx];
                else r.status = ST_RANGE;
            end
        endcase
        r.count     = OUT_CNT_W'(held_values.size());
        r.empty_res = (held_values.size() == 0);
        return r;
    endfunction

    function automatic int sender_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet_mode || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // 0: general mix, 1: mostly present values, 2: mostly fresh values
    function automatic logic signed [VAL_W-1:0] pick_value(int kind);
        int r;
        r = $urandom_range(0, 9);
        if (kind == 1 && r < 8) r = 0;
        if (kind == 2 && r < 7) r = 9;
        if (r < 4 && held_values.size() > 0)
            return held_values[$urandom_range(0, held_values.size() - 1)];
        if (r < 7) return $signed(VAL_W'($urandom_range(0, 15))) - 8;
        if (r == 7) begin
            case ($urandom_range(0, 3))
                0: return VAL_MIN;
                1: return VAL_MAX;
                2: return '0;
                default: return -1;
            endcase
        end
        return $urandom;
    endfunction

    task automatic send_word(t_func f, logic signed [VAL_W-1:0] v, logic [IDX_W-1:0] idx,
                             bit typed, t_set_result typed_res);
        int gap;
        t_set_result r;
        gap = sender_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_func  <= f;
        i_value <= v;
        i_index <= idx;
        do begin
            @(posedge i_clk);
        end while (!o_ready);
        r = apply_set_op(f, v, idx);
        pending_results.push_back(typed ? typed_res : r);
    endtask

    task automatic send_random(t_func f, int kind);
        t_set_result unused;
        logic [IDX_W-1:0] idx;
        if ($urandom_range(0, 9) < 7)
            idx = IDX_W'($urandom_range(0, held_values.size()));
        else
            idx = IDX_W'($urandom_range(0, 127));
        unused = '{1'b0, '0, '0, 1'b0, ST_OK};
        send_word(f, pick_value(kind), idx, 1'b0, unused);
        random_sent++;
    endtask

    task automatic wait_for_drain();
        i_valid <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (pending_results.size() != 0);
    endtask

    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            i_ready <= 1'b0;
            hold_cycles--;
        end else begin
            i_ready <= 1'b1;
            if (!quiet_mode && $urandom_range(0, 3) == 0)
                hold_cycles = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                          : $urandom_range(1, 3);
        end
    end

    always @(posedge i_clk) begin
        t_set_result e;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                error_count++;
                if (error_count <= 10)
                    $display("unexpected result word: found=%0b rd=%0d cnt=%0d st=%0d",
                             o_found, o_read_value, o_count, o_status);
            end else begin
                e = pending_results.pop_front();
                if (o_found !== e.found || o_read_value !== e.read_value ||
                    o_count !== e.count || o_empty_res !== e.empty_res ||
                    o_status !== e.status) begin
                    error_count++;
                    if (error_count <= 10) begin
                        $write("mismatch: exp found=%0b rd=%0d cnt=%0d empty=%0b st=%0d, ",
                               e.found, e.read_value, e.count, e.empty_res, e.status);
                        $display("got found=%0b rd=%0d cnt=%0d empty=%0b st=%0d",
                                 o_found, o_read_value, o_count, o_empty_res, o_status);
                    end
                end
            end
        end
    end

    initial begin
        #40_000_000;
        $display("unique_value_set_table verification failed");
        $finish;
    end

    initial begin
        int phase;
        int extra;
        int r;
        t_set_result unused;
        unused = '{1'b0, '0, '0, 1'b0, ST_OK};
        directed_rows = '{
            '{FUNC_READ,   '0,      7'd0,   1'b1, '{1'b0, '0,      8'd0, 1'b1, ST_RANGE}},
            '{FUNC_QUERY,  '0,      7'd5,   1'b1, '{1'b0, '0,      8'd0, 1'b1, ST_MISSING}},
            '{FUNC_REMOVE, VAL_MIN, 7'd127, 1'b1, '{1'b0, '0,      8'd0, 1'b1, ST_MISSING}},
            '{FUNC_INSERT, VAL_MIN, 7'd0,   1'b1, '{1'b0, '0,      8'd1, 1'b0, ST_OK}},
            '{FUNC_INSERT, VAL_MAX, 7'd0,   1'b1, '{1'b0, '0,      8'd2, 1'b0, ST_OK}},
            '{FUNC_INSERT, '0,      7'd0,   1'b1, '{1'b0, '0,      8'd3, 1'b0, ST_OK}},
            '{FUNC_INSERT, VAL_MIN, 7'd0,   1'b1, '{1'b1, '0,      8'd3, 1'b0, ST_DUP}},
            '{FUNC_INSERT, -32'sd1, 7'd127, 1'b0, unused},
            '{FUNC_QUERY,  VAL_MAX, 7'd0,   1'b0, unused},
            '{FUNC_QUERY,  32'sd1,  7'd0,   1'b0, unused},
            '{FUNC_READ,   '0,      7'd0,   1'b1, '{1'b0, VAL_MIN, 8'd4, 1'b0, ST_OK}},
            '{FUNC_READ,   '0,      7'd3,   1'b0, unused},
            '{FUNC_READ,   '0,      7'd4,   1'b1, '{1'b0, '0,      8'd4, 1'b0, ST_RANGE}},
            '{FUNC_READ,   VAL_MAX, 7'd127, 1'b1, '{1'b0, '0,      8'd4, 1'b0, ST_RANGE}},
            '{FUNC_REMOVE, VAL_MAX, 7'd0,   1'b0, unused},
            '{FUNC_READ,   '0,      7'd1,   1'b0, unused},
            '{FUNC_READ,   '0,      7'd3,   1'b0, unused},
            '{FUNC_REMOVE, -32'sd1, 7'd0,   1'b0, unused},
            '{FUNC_REMOVE, VAL_MAX, 7'd0,   1'b0, unused},
            '{FUNC_REMOVE, VAL_MIN, 7'd0,   1'b0, unused},
            '{FUNC_READ,   '0,      7'd0,   1'b0, unused},
            '{FUNC_REMOVE, '0,      7'd0,   1'b0, unused},
            '{FUNC_QUERY,  '0,      7'd0,   1'b0, unused},
            '{FUNC_INSERT, 32'sh5555_5555, 7'd0, 1'b0, unused},
            '{FUNC_INSERT, 32'shaaaa_aaaa, 7'd0, 1'b0, unused}
        };

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_word(directed_rows[i].func, directed_rows[i].value, directed_rows[i].index,
                      directed_rows[i].typed, directed_rows[i].res);
        wait_for_drain();

        phase = 0;
        while (random_sent < RANDOM_ITEMS) begin
            quiet_mode = ($urandom_range(0, 3) == 0);
            extra = 0;
            case (phase % 4)
                0: begin
                    // fill up to capacity, then keep pushing against the full table
                    while (held_values.size() < CAPACITY || extra < 12) begin
                        if (held_values.size() == CAPACITY) extra++;
                        r = $urandom_range(0, 19);
                        if (r < 16) send_random(FUNC_INSERT, 2);
                        else if (r < 18) send_random(FUNC_INSERT, 1);
                        else if (r == 18) send_random(FUNC_QUERY, 0);
                        else send_random(FUNC_READ, 0);
                    end
                end
                2: begin
                    while (held_values.size() > 0 || extra < 6) begin
                        if (held_values.size() == 0) extra++;
                        r = $urandom_range(0, 19);
                        if (r < 17) send_random(FUNC_REMOVE, 1);
                        else send_random(t_func'($urandom_range(0, 3)), 0);
                    end
                end
                default: begin
                    repeat (150) send_random(t_func'($urandom_range(0, 3)), 0);
                end
            endcase
            wait_for_drain();
            phase++;
        end

        repeat (50) @(posedge i_clk);
        if (error_count == 0)
            $display("unique_value_set_table verification clean");
        else
            $display("unique_value_set_table verification failed");
        $finish;
    end

endmodule
`default_nettype wire
